>>> src/sha1_hash_core_assert.svh
// Assertion macros for the SHA-1 hash core.
// Included by the top-level RTL file, which checks its own sequencing; no other dependencies.
`ifndef SHA1_HASH_CORE_ASSERT_SVH
`define SHA1_HASH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define SHA1HC_ASSERT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sha1_hash_core: assertion failed");
// Next-cycle implication.
`define SHA1HC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sha1_hash_core: assertion failed");
`else
`define SHA1HC_ASSERT(name, clk, rst_n, ante, cons)
`define SHA1HC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

>>> src/sha1hc_pkg.sv
// Shared types, constants and functions of the SHA-1 hash core.
// No dependencies; imported by every module of the core.
package sha1hc_pkg;

	localparam int unsigned WORD_W  = 32;
	localparam int unsigned NB_W    = 3;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned CNT_W   = 61;
	localparam int unsigned ROUND_W = 7;
	localparam int unsigned WCNT_W  = 4;
	localparam int unsigned BOFF_W  = 2;
	localparam int unsigned HASH_N  = 5;
	localparam int unsigned SCHED_N = 16;

	typedef logic [WORD_W-1:0] word_t;

	localparam logic [NB_W-1:0]    NB_NONE    = 3'd0;
	localparam logic [NB_W-1:0]    NB_ONE     = 3'd1;
	localparam logic [NB_W-1:0]    NB_FULL    = 3'd4;
	localparam logic [WCNT_W-1:0]  WCNT_LEN   = 4'd14;
	localparam logic [WCNT_W-1:0]  WCNT_TOP   = 4'd15;
	localparam logic [IDX_W-1:0]   IDX_LAST   = 3'd4;
	localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;
	localparam logic [ROUND_W-1:0] ROUND_CH_END   = 7'd20;
	localparam logic [ROUND_W-1:0] ROUND_PARA_END = 7'd40;
	localparam logic [ROUND_W-1:0] ROUND_MAJ_END  = 7'd60;
	localparam word_t PAD_WORD = 32'h8000_0000;

	typedef enum logic [1:0] {
		GRP_CH,
		GRP_PAR_A,
		GRP_MAJ,
		GRP_PAR_B
	} grp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_FILL,
		ST_LEN_HI,
		ST_LEN_LO,
		ST_ROUND,
		ST_UPDATE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic push;
		logic shift;
	} msg_ctl_t;

	typedef struct packed {
		logic [BOFF_W-1:0] poff;
		logic [WCNT_W-1:0] wcnt;
		logic              fills_block;
	} msg_sts_t;

	typedef struct packed {
		logic load;
		logic round;
		logic update;
		logic clear;
		grp_t grp;
	} rnd_ctl_t;

	function automatic word_t h_init(input int unsigned i);
		word_t v;
		case (i)
			0: v = 32'h6745_2301;
			1: v = 32'hEFCD_AB89;
			2: v = 32'h98BA_DCFE;
			3: v = 32'h1032_5476;
			default: v = 32'hC3D2_E1F0;
		endcase
		return v;
	endfunction

	function automatic word_t k_of(input grp_t g);
		word_t v;
		case (g)
			GRP_CH:    v = 32'h5A82_7999;
			GRP_PAR_A: v = 32'h6ED9_EBA1;
			GRP_MAJ:   v = 32'h8F1B_BCDC;
			GRP_PAR_B: v = 32'hCA62_C1D6;
			default:   v = 32'h5A82_7999;
		endcase
		return v;
	endfunction

	function automatic word_t f_of(input grp_t g, input word_t b, input word_t c,
			input word_t d);
		word_t v;
		case (g)
			GRP_CH:  v = (b & c) | (~b & d);
			GRP_MAJ: v = (b & c) | (b & d) | (c & d);
			default: v = b ^ c ^ d;
		endcase
		return v;
	endfunction

endpackage

>>> src/sha1hc_msg.sv
// Byte packer and 16-word message schedule shift line of the SHA-1 core.
// Depends on sha1hc_pkg.
module sha1hc_msg import sha1hc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  msg_ctl_t        ctl,
	input  word_t           src_data,
	input  logic [NB_W-1:0] src_nb,
	output msg_sts_t        sts,
	output word_t           wt
);

	word_t             pword_q;
	logic [BOFF_W-1:0] poff_q;
	logic [WCNT_W-1:0] wcnt_q;
	word_t             w_q [SCHED_N];

	word_t                 dmask;
	logic [2*WORD_W-1:0]   cat;
	logic [NB_W-1:0]       total;
	logic                  has_word;
	word_t                 sched_nxt;

	always_comb begin
		case (src_nb)
			NB_NONE: dmask = 32'h0000_0000;
			3'd1:    dmask = 32'hFF00_0000;
			3'd2:    dmask = 32'hFFFF_0000;
			3'd3:    dmask = 32'hFFFF_FF00;
			default: dmask = 32'hFFFF_FFFF;
		endcase
	end

	// place the new bytes straight after the held ones
	assign cat = {pword_q, {WORD_W{1'b0}}}
		| ({src_data & dmask, {WORD_W{1'b0}}} >> {poff_q, 3'b000});
	assign total    = {1'b0, poff_q} + src_nb;
	assign has_word = total[2];

	assign sched_nxt = {w_q[13][30:0] ^ w_q[8][30:0] ^ w_q[2][30:0] ^ w_q[0][30:0],
		w_q[13][31] ^ w_q[8][31] ^ w_q[2][31] ^ w_q[0][31]};

	assign sts.poff        = poff_q;
	assign sts.wcnt        = wcnt_q;
	assign sts.fills_block = has_word && (wcnt_q == WCNT_TOP);
	assign wt              = w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pword_q <= '0;
			poff_q  <= '0;
			wcnt_q  <= '0;
		end else if (ctl.push) begin
			poff_q <= total[BOFF_W-1:0];
			if (has_word) begin
				pword_q <= cat[WORD_W-1:0];
				wcnt_q  <= wcnt_q + 1'b1;
			end else begin
				pword_q <= cat[2*WORD_W-1:WORD_W];
			end
		end
	end

	// one line serves as block buffer and as the schedule window
	always_ff @(posedge clk) begin
		if (ctl.push && has_word) begin
			for (int i = 0; i < SCHED_N - 1; i++)
				w_q[i] <= w_q[i+1];
			w_q[SCHED_N-1] <= cat[2*WORD_W-1:WORD_W];
		end else if (ctl.shift) begin
			for (int i = 0; i < SCHED_N - 1; i++)
				w_q[i] <= w_q[i+1];
			w_q[SCHED_N-1] <= sched_nxt;
		end
	end

endmodule

>>> src/sha1hc_round.sv
// Chaining value and shared round unit of the SHA-1 core.
// Depends on sha1hc_pkg.
module sha1hc_round import sha1hc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  rnd_ctl_t         ctl,
	input  word_t            wt,
	input  logic [IDX_W-1:0] sel,
	output word_t            sel_word
);

	word_t h_q [HASH_N];
	word_t a_q, b_q, c_q, d_q, e_q;
	word_t tmp;

	assign tmp = {a_q[26:0], a_q[31:27]} + f_of(ctl.grp, b_q, c_q, d_q) + e_q
		+ k_of(ctl.grp) + wt;

	always_comb begin
		sel_word = h_q[0];
		for (int i = 0; i < HASH_N; i++)
			if (sel == IDX_W'(i))
				sel_word = h_q[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HASH_N; i++)
				h_q[i] <= h_init(i);
		end else if (ctl.clear) begin
			for (int i = 0; i < HASH_N; i++)
				h_q[i] <= h_init(i);
		end else if (ctl.update) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.round) begin
			a_q <= tmp;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

>>> src/sha1_hash_core.sv
// Top level of the streaming SHA-1 core: sequencer, byte count and digest output register.
// Depends on sha1hc_pkg, sha1hc_msg, sha1hc_round and sha1_hash_core_assert.svh.
//
// Streaming SHA-1 digest. Each input transfer carries one big-endian message word, the
// number of its leading valid bytes (values above four count as four) and a last flag;
// short words are packed byte-exact, so later words continue at byte granularity. The word
// that completes a 64-byte block starts the compression: one shared round unit runs the
// 80 rounds at one per cycle and then adds into the chaining value, and the input stalls
// until that is done. On a last transfer the core appends the 0x80 pad byte, zero words
// (one per cycle, pausing while a filled block is compressed) and the 64-bit bit length,
// compresses once or twice more, and then presents the five digest words in order, index
// 0 first, the fifth marked with last_word. An output register holds each word until it
// is taken; the next message is accepted as soon as the fifth word is loaded. The byte
// count wraps modulo 2^61.
`include "sha1_hash_core_assert.svh"
module sha1_hash_core import sha1hc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [31:0]      data_word,
	input  logic [2:0]       valid_bytes,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);

	state_t               state_q, state_d, ret_q, seq_nxt;
	logic [ROUND_W-1:0]   rnd_q;
	logic [IDX_W-1:0]     idx_q;
	logic [CNT_W-1:0]     mbytes_q;
	logic                 out_valid_q;
	word_t                digest_q;
	logic [IDX_W-1:0]     word_index_q;
	logic                 last_word_q;

	msg_ctl_t             mctl;
	msg_sts_t             msts;
	rnd_ctl_t             rctl;
	word_t                src_data;
	logic [NB_W-1:0]      src_nb;
	logic [NB_W-1:0]      in_nb;
	word_t                wt;
	word_t                sel_word;
	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign in_nb    = (valid_bytes > NB_FULL) ? NB_FULL : valid_bytes;

	// pick what the packer appends in this state
	always_comb begin
		case (state_q)
			ST_IDLE: begin
				src_data = data_word;
				src_nb   = in_nb;
			end
			ST_PAD: begin
				src_data = PAD_WORD;
				src_nb   = NB_ONE;
			end
			ST_FILL: begin
				src_data = '0;
				src_nb   = NB_FULL - {1'b0, msts.poff};
			end
			ST_LEN_HI: begin
				src_data = mbytes_q[CNT_W-1:CNT_W-WORD_W];
				src_nb   = NB_FULL;
			end
			ST_LEN_LO: begin
				src_data = {mbytes_q[CNT_W-WORD_W-1:0], 3'b000};
				src_nb   = NB_FULL;
			end
			default: begin
				src_data = '0;
				src_nb   = NB_NONE;
			end
		endcase
	end

	always_comb begin
		state_d     = state_q;
		seq_nxt     = state_q;
		mctl.push   = 1'b0;
		mctl.shift  = 1'b0;
		rctl.load   = 1'b0;
		rctl.round  = 1'b0;
		rctl.update = 1'b0;
		rctl.clear  = 1'b0;
		out_load    = 1'b0;
		if (rnd_q < ROUND_CH_END)
			rctl.grp = GRP_CH;
		else if (rnd_q < ROUND_PARA_END)
			rctl.grp = GRP_PAR_A;
		else if (rnd_q < ROUND_MAJ_END)
			rctl.grp = GRP_MAJ;
		else
			rctl.grp = GRP_PAR_B;

		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					mctl.push = 1'b1;
					seq_nxt   = last ? ST_PAD : ST_IDLE;
				end
			end
			ST_PAD: begin
				mctl.push = 1'b1;
				seq_nxt   = ST_FILL;
			end
			ST_FILL: begin
				// stop at byte 56 of the block; the length takes the last two words
				if (msts.poff == '0 && msts.wcnt == WCNT_LEN) begin
					state_d = ST_LEN_HI;
				end else begin
					mctl.push = 1'b1;
					seq_nxt   = ST_FILL;
				end
			end
			ST_LEN_HI: begin
				mctl.push = 1'b1;
				seq_nxt   = ST_LEN_LO;
			end
			ST_LEN_LO: begin
				mctl.push = 1'b1;
				seq_nxt   = ST_OUT;
			end
			ST_ROUND: begin
				rctl.round = 1'b1;
				mctl.shift = 1'b1;
				if (rnd_q == ROUND_LAST)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				rctl.update = 1'b1;
				state_d     = ret_q;
			end
			ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					if (idx_q == IDX_LAST) begin
						rctl.clear = 1'b1;
						state_d    = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// a full block diverts to the rounds, then resume where the packer left off
		if (mctl.push) begin
			state_d = seq_nxt;
			if (msts.fills_block) begin
				state_d   = ST_ROUND;
				rctl.load = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			rnd_q    <= '0;
			idx_q    <= '0;
			mbytes_q <= '0;
		end else begin
			state_q <= state_d;
			if (rctl.load) begin
				ret_q <= seq_nxt;
				rnd_q <= '0;
			end else if (rctl.round) begin
				rnd_q <= rnd_q + 1'b1;
			end
			if (out_load)
				idx_q <= (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
			if (rctl.clear)
				mbytes_q <= '0;
			else if (in_acc)
				mbytes_q <= mbytes_q + CNT_W'(in_nb);
		end
	end

	// output register: hold a word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			digest_q     <= sel_word;
			word_index_q <= idx_q;
			last_word_q  <= (idx_q == IDX_LAST);
		end
	end

	assign out_valid   = out_valid_q;
	assign digest_word = digest_q;
	assign word_index  = word_index_q;
	assign last_word   = last_word_q;

	sha1hc_msg u_msg (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (mctl),
		.src_data (src_data),
		.src_nb   (src_nb),
		.sts      (msts),
		.wt       (wt)
	);

	sha1hc_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rctl),
		.wt       (wt),
		.sel      (idx_q),
		.sel_word (sel_word)
	);

	`SHA1HC_ASSERT(a_len_aligned, clk, arst_n, state_q == ST_LEN_HI, msts.poff == '0 && msts.wcnt == WCNT_LEN)
	`SHA1HC_ASSERT(a_out_block_empty, clk, arst_n, state_q == ST_OUT, msts.poff == '0 && msts.wcnt == '0)
	`SHA1HC_ASSERT(a_out_last_tag, clk, arst_n, out_valid_q, last_word_q == (word_index_q == IDX_LAST))
	`SHA1HC_ASSERT_NXT(a_last_to_pad, clk, arst_n, in_acc && last, state_q == ST_PAD || state_q == ST_ROUND)

endmodule
